// ===== rtl/core/bfg_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the bilateral filter.
package bfg_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int MAX_RADIUS    = 7;
  localparam int WEIGHT_BITS   = 16;
  localparam int SPAN          = 2 * MAX_RADIUS + 1;
  localparam int SPATIAL_DEPTH = SPAN * SPAN;
  localparam int FRAME_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int RANGE_DEPTH   = 256;

  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int SC_W    = 10;
  localparam int RAD_W   = 3;
  localparam int CNT_W   = 4;
  localparam int SIDX_W  = 8;
  localparam int PIX_W   = 8;
  localparam int DEN_W   = 24;
  localparam int NUM_W   = 32;
  localparam int REM_W   = NUM_W + 1;
  localparam int QUO_W   = 9;
  localparam int DCNT_W  = 4;

  localparam logic [1:0] REQ_PIXEL   = 2'd0;
  localparam logic [1:0] REQ_RANGE   = 2'd1;
  localparam logic [1:0] REQ_SPATIAL = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_MODE   = 3'd3;
  localparam logic [2:0] CFG_FILL   = 3'd4;

  localparam logic [1:0] EDGE_CLAMP = 2'd0;
  localparam logic [1:0] EDGE_FILL  = 2'd1;
  localparam logic [1:0] EDGE_WRAP  = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_q;
    logic setup;
    logic rd_centre;
    logic lat_centre;
    logic tap_issue;
    logic div_init;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic setup_done;
    logic tap_last;
    logic pipe_busy;
    logic div_last;
  } stat_t;

endpackage

// ===== rtl/core/bfg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bfg_ctrl.sv =====
// Query sequencer: setup, centre fetch, window sweep, drain, divide, result hold.
module bfg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          req_type,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output bfg_pkg::cmd_t       cmd,
  input  bfg_pkg::stat_t      stat
);
  import bfg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_CRD   = 3'd2;
  localparam logic [2:0] S_CLAT  = 3'd3;
  localparam logic [2:0] S_TAPS  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && req_type == REQ_QUERY) begin
          cmd.load_q = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.setup_done) state_next = S_CRD;
      end
      S_CRD: begin
        cmd.rd_centre = 1'b1;
        state_next    = S_CLAT;
      end
      S_CLAT: begin
        cmd.lat_centre = 1'b1;
        state_next     = S_TAPS;
      end
      S_TAPS: begin
        cmd.tap_issue = 1'b1;
        if (stat.tap_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/bfg_datapath.sv =====
// Config registers, memories, window address generation, weight pipeline and divider.
module bfg_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [bfg_pkg::SIZE_W-1:0]  cfg_data,
  input  logic [1:0]                  req_type,
  input  logic [bfg_pkg::COORD_W-1:0] row,
  input  logic [bfg_pkg::COORD_W-1:0] col,
  input  logic [bfg_pkg::PIX_W-1:0]   pixel_value,
  input  logic [7:0]                  table_index,
  input  logic [15:0]                 weight_value,
  input  bfg_pkg::cmd_t               cmd,
  output bfg_pkg::stat_t              stat,
  output logic [bfg_pkg::PIX_W-1:0]   filtered_value,
  output logic                        zero_weight
);
  import bfg_pkg::*;

  localparam logic signed [SC_W-1:0] SC_ONE = SC_W'(1);

  // configuration
  logic [SIZE_W-1:0] cfg_w, cfg_h;
  logic [RAD_W-1:0]  cfg_r;
  logic [1:0]        cfg_mode;
  logic [PIX_W-1:0]  cfg_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= SIZE_W'(MAX_WIDTH);
      cfg_h    <= SIZE_W'(MAX_HEIGHT);
      cfg_r    <= RAD_W'(2);
      cfg_mode <= EDGE_WRAP;
      cfg_fill <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  cfg_w    <= cfg_data;
        CFG_HEIGHT: cfg_h    <= cfg_data;
        CFG_RADIUS: cfg_r    <= cfg_data[RAD_W-1:0];
        CFG_MODE:   cfg_mode <= cfg_data[1:0];
        CFG_FILL:   cfg_fill <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0]  r_eff;
  assign w_eff = (cfg_w == '0) ? SIZE_W'(1) :
                 (cfg_w > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : cfg_w;
  assign h_eff = (cfg_h == '0) ? SIZE_W'(1) :
                 (cfg_h > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : cfg_h;
  assign r_eff = (cfg_r == '0) ? RAD_W'(1) : cfg_r;

  logic signed [SC_W-1:0] w_s, h_s;
  assign w_s = signed'({1'b0, w_eff});
  assign h_s = signed'({1'b0, h_eff});

  // memories
  logic                    frame_we, range_we, spatial_we;
  logic [15:0]             frame_waddr, frame_raddr;
  logic [PIX_W-1:0]        frame_rdata;
  logic [7:0]              range_raddr;
  logic [WEIGHT_BITS-1:0]  range_rdata, spatial_rdata;
  logic [SIDX_W-1:0]       spatial_raddr;

  assign frame_we    = cmd.accept && req_type == REQ_PIXEL;
  assign range_we    = cmd.accept && req_type == REQ_RANGE;
  assign spatial_we  = cmd.accept && req_type == REQ_SPATIAL &&
                       {1'b0, table_index} < 9'(SPATIAL_DEPTH);
  assign frame_waddr = {row, col};

  bfg_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk(clk), .we(frame_we), .waddr(frame_waddr), .wdata(pixel_value),
    .raddr(frame_raddr), .rdata(frame_rdata)
  );
  bfg_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(RANGE_DEPTH)) u_range (
    .clk(clk), .we(range_we), .waddr(table_index), .wdata(weight_value),
    .raddr(range_raddr), .rdata(range_rdata)
  );
  bfg_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(SPATIAL_DEPTH)) u_spatial (
    .clk(clk), .we(spatial_we), .waddr(table_index), .wdata(weight_value),
    .raddr(spatial_raddr), .rdata(spatial_rdata)
  );

  // query coordinates
  logic [COORD_W-1:0]     cy, cx, cy_n, cx_n;
  logic [RAD_W-1:0]       rr;
  logic signed [SC_W-1:0] ry, wy, rx, wx, rx0, wx0;
  logic [CNT_W-1:0]       ix, iy, span_m1;
  logic [SIDX_W-1:0]      sidx, rbase, sidx_init;

  assign cy_n = ({1'b0, row} >= h_eff) ? COORD_W'(h_eff - 1'b1) : row;
  assign cx_n = ({1'b0, col} >= w_eff) ? COORD_W'(w_eff - 1'b1) : col;
  assign span_m1   = {rr, 1'b0};
  assign sidx_init = SIDX_W'((RAD_W'(MAX_RADIUS) - rr) * (SPAN + 1));

  assign stat.setup_done = !wy[SC_W-1] && !wx0[SC_W-1];
  assign stat.tap_last   = (ix == span_m1) && (iy == span_m1);

  // border mapping for the current tap
  logic                   y_in, x_in, tap_oob;
  logic [COORD_W-1:0]     my, mx;
  logic signed [SC_W-1:0] wy_inc, wx_inc;

  assign y_in = !ry[SC_W-1] && ry < h_s;
  assign x_in = !rx[SC_W-1] && rx < w_s;

  always_comb begin
    tap_oob = 1'b0;
    unique case (cfg_mode)
      EDGE_CLAMP: begin
        my = ry[SC_W-1] ? '0 : (y_in ? ry[COORD_W-1:0] : COORD_W'(h_eff - 1'b1));
        mx = rx[SC_W-1] ? '0 : (x_in ? rx[COORD_W-1:0] : COORD_W'(w_eff - 1'b1));
      end
      EDGE_FILL: begin
        my      = ry[COORD_W-1:0];
        mx      = rx[COORD_W-1:0];
        tap_oob = !(y_in && x_in);
      end
      default: begin
        my = wy[COORD_W-1:0];
        mx = wx[COORD_W-1:0];
      end
    endcase
  end

  assign wy_inc = (wy + SC_ONE == h_s) ? '0 : wy + SC_ONE;
  assign wx_inc = (wx + SC_ONE == w_s) ? '0 : wx + SC_ONE;

  assign frame_raddr   = cmd.rd_centre ? {cy, cx} : {my, mx};
  assign spatial_raddr = sidx;

  // weight pipeline
  logic                   s1_valid, s2_valid, s3_valid, s1_oob;
  logic [PIX_W-1:0]       centre, s1_pix, s2_pix, s3_pix, diff;
  logic [WEIGHT_BITS-1:0] s2_sw, s3_wt;
  logic [2*WEIGHT_BITS-1:0] wprod;
  logic [DEN_W-1:0]       den;
  logic [NUM_W-1:0]       num;

  assign s1_pix      = s1_oob ? cfg_fill : frame_rdata;
  assign diff        = (s1_pix > centre) ? s1_pix - centre : centre - s1_pix;
  assign range_raddr = diff;
  assign wprod       = s2_sw * range_rdata;
  assign stat.pipe_busy = s1_valid || s2_valid || s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.tap_issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_oob <= tap_oob;
    s2_pix <= s1_pix;
    s2_sw  <= spatial_rdata;
    s3_pix <= s2_pix;
    s3_wt  <= wprod[2*WEIGHT_BITS-1:WEIGHT_BITS];
    if (s3_valid) begin
      den <= den + DEN_W'(s3_wt);
      num <= num + NUM_W'(s3_wt) * NUM_W'(s3_pix);
    end
    if (cmd.load_q) begin
      cy  <= cy_n;
      cx  <= cx_n;
      rr  <= r_eff;
      ry  <= signed'({2'b0, cy_n}) - signed'({7'b0, r_eff});
      wy  <= signed'({2'b0, cy_n}) - signed'({7'b0, r_eff});
      rx0 <= signed'({2'b0, cx_n}) - signed'({7'b0, r_eff});
      wx0 <= signed'({2'b0, cx_n}) - signed'({7'b0, r_eff});
    end
    if (cmd.setup) begin
      if (wy[SC_W-1])  wy  <= wy + h_s;
      if (wx0[SC_W-1]) wx0 <= wx0 + w_s;
    end
    if (cmd.lat_centre) begin
      centre <= frame_rdata;
      num    <= '0;
      den    <= '0;
      ix     <= '0;
      iy     <= '0;
      rx     <= rx0;
      wx     <= wx0;
      sidx   <= sidx_init;
      rbase  <= sidx_init;
    end
    if (cmd.tap_issue) begin
      if (ix == span_m1) begin
        ix    <= '0;
        iy    <= iy + 1'b1;
        rx    <= rx0;
        wx    <= wx0;
        ry    <= ry + SC_ONE;
        wy    <= wy_inc;
        rbase <= rbase + SIDX_W'(SPAN);
        sidx  <= rbase + SIDX_W'(SPAN);
      end else begin
        ix   <= ix + 1'b1;
        rx   <= rx + SC_ONE;
        wx   <= wx_inc;
        sidx <= sidx + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [REM_W-1:0]  rem, dshift;
  logic [QUO_W-1:0]  quo;
  logic [DCNT_W-1:0] dcnt;
  logic              zero;

  assign dshift        = {{(REM_W-DEN_W){1'b0}}, den} << dcnt;
  assign stat.div_last = (dcnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= REM_W'(num) + REM_W'(den >> 1);
      quo  <= '0;
      dcnt <= DCNT_W'(QUO_W - 1);
      zero <= (den == '0);
    end else if (cmd.div_step) begin
      if (rem >= dshift) begin
        rem       <= rem - dshift;
        quo[dcnt] <= 1'b1;
      end
      dcnt <= dcnt - 1'b1;
    end
  end

  assign zero_weight    = zero;
  assign filtered_value = zero ? centre : (quo[QUO_W-1] ? '1 : quo[PIX_W-1:0]);

endmodule

// ===== rtl/core/bilateral_filter_gray.sv =====
// Top level of the grayscale bilateral filter: sequencer plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | into      | in_valid/in_stall  | req_type row col pixel_value table_index
//          |           |                    | weight_value
//  out     | out of    | out_valid/out_stall| filtered_value zero_weight
//  cfg     | into      | cfg_we             | cfg_index cfg_data
//
// A load transaction produces nothing.
// A query offers its result after setup, which reduces the wrap offsets, centre read and
// latch, one window pixel a cycle through the single frame memory read port, the pipeline
// drain and the divider.
// Reset (rst, synchronous) returns the sequencer to idle and loads register defaults;
// the memories are not cleared.
// While a query is in flight in_stall stays high; the result holds until out_stall drops,
// and the input opens the cycle after the result is taken.
module bilateral_filter_gray (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [bfg_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [bfg_pkg::COORD_W-1:0] row,
  input  logic [bfg_pkg::COORD_W-1:0] col,
  input  logic [bfg_pkg::PIX_W-1:0]   pixel_value,
  input  logic [7:0]                  table_index,
  input  logic [15:0]                 weight_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfg_pkg::PIX_W-1:0]   filtered_value,
  output logic                        zero_weight
);
  import bfg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the handshakes and steps the datapath
  bfg_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .req_type(req_type), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat)
  );

  // datapath: registers, memories, weight pipeline and divider
  bfg_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_type(req_type), .row(row), .col(col), .pixel_value(pixel_value),
    .table_index(table_index), .weight_value(weight_value),
    .cmd(cmd), .stat(stat),
    .filtered_value(filtered_value), .zero_weight(zero_weight)
  );

  // a pending result blocks new input
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");

  // an accepted query keeps the input closed next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_QUERY) |=> in_stall)
    else $error("query did not start");

  // a load completes in its own cycle
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type != REQ_QUERY) |=> !in_stall && !out_valid)
    else $error("load stalled or produced a result");

endmodule

// ===== dv/tb_bilateral_filter_gray.sv =====
// Self-checking testbench for the grayscale bilateral filter: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_bilateral_filter_gray;
  import bfg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction on either channel
  localparam int LONG_HOLD      = 600;    // receiver hold-off, well past one query
  localparam int RANDOM_PER_SET = 30;     // random transactions per frame setting

  // One request as it goes over the input channel.
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  r;
    logic [7:0]  c;
    logic [7:0]  pix;
    logic [7:0]  idx;
    logic [15:0] wt;
  } request_t;

  // Directed row: request plus an optional hand-typed expected pixel.
  typedef struct {
    request_t    req;
    bit          typed;
    logic [7:0]  exp_pix;
    logic        exp_zero;
  } directed_row_t;

  typedef struct {
    logic [7:0] pix;
    logic       zero;
  } filtered_t;

  // One frame setting: raw register values, out-of-range ones included.
  typedef struct {
    logic [8:0] w;
    logic [8:0] h;
    logic [2:0] rad;
    logic [1:0] mode;
    logic [7:0] fill;
  } frame_setting_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_WIDTH;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_PIXEL;
  logic [7:0]  row = '0;
  logic [7:0]  col = '0;
  logic [7:0]  pixel_value = '0;
  logic [7:0]  table_index = '0;
  logic [15:0] weight_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  filtered_value;
  logic        zero_weight;

  bilateral_filter_gray dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .row(row), .col(col), .pixel_value(pixel_value),
    .table_index(table_index), .weight_value(weight_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_value(filtered_value), .zero_weight(zero_weight)
  );

  always #10 clk = ~clk;

  // Shadow of the block: memories and registers as the block should hold them.
  logic [7:0]  shadow_frame [FRAME_DEPTH];
  logic [15:0] shadow_range [RANGE_DEPTH];
  logic [15:0] shadow_spatial [SPATIAL_DEPTH];
  int unsigned sh_width = 256, sh_height = 256, sh_radius = 2, sh_mode = 2, sh_fill = 0;

  filtered_t pending_pixels[$];   // filtered pixels still owed by the block
  int  errors = 0;
  int  queries_sent = 0;
  int  zero_seen = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;         // no idling on either side while set
  bit  long_hold_req = 1'b0;

  // Fold a coordinate into the frame; 0 means "outside, use the fill value".
  function automatic bit fold_coord(input int c, input int n, output int o);
    if (c >= 0 && c < n) begin
      o = c;
      return 1'b1;
    end
    if (sh_mode == EDGE_CLAMP) begin
      o = (c < 0) ? 0 : n - 1;
      return 1'b1;
    end
    if (sh_mode == EDGE_FILL) begin
      o = 0;
      return 1'b0;
    end
    o = ((c % n) + n) % n;  // wrap, and the unused mode acts as wrap
    return 1'b1;
  endfunction

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic filtered_t filter_at(input int qr, input int qc);
    int w, h, rad, cy, cx, yy, xx, dy, dx;
    bit in_y, in_x;
    int unsigned cen, pix, diff;
    longint unsigned wt, num, den, quo;
    filtered_t res;
    w   = clamp_size(sh_width, MAX_WIDTH);
    h   = clamp_size(sh_height, MAX_HEIGHT);
    rad = clamp_size(sh_radius, MAX_RADIUS);
    cy  = (qr >= h) ? h - 1 : qr;
    cx  = (qc >= w) ? w - 1 : qc;
    cen = shadow_frame[cy * MAX_WIDTH + cx];
    num = 0;
    den = 0;
    for (dy = -rad; dy <= rad; dy++) begin
      for (dx = -rad; dx <= rad; dx++) begin
        in_y = fold_coord(cy + dy, h, yy);
        in_x = fold_coord(cx + dx, w, xx);
        pix  = (in_y && in_x) ? shadow_frame[yy * MAX_WIDTH + xx] : sh_fill;
        diff = (pix > cen) ? pix - cen : cen - pix;
        wt   = (longint'(shadow_spatial[(dy + MAX_RADIUS) * SPAN + dx + MAX_RADIUS])
                * longint'(shadow_range[diff])) >> WEIGHT_BITS;
        den += wt;
        num += wt * pix;
      end
    end
    if (den == 0) begin
      res.pix  = cen[7:0];
      res.zero = 1'b1;
    end else begin
      quo      = (num + den / 2) / den;
      res.pix  = (quo > 255) ? 8'd255 : quo[7:0];
      res.zero = 1'b0;
    end
    return res;
  endfunction

  // Apply an accepted request to the shadow; owe a pixel for a query.
  task automatic absorb(input request_t q);
    case (q.kind)
      REQ_PIXEL:   shadow_frame[q.r * MAX_WIDTH + q.c] = q.pix;
      REQ_RANGE:   shadow_range[q.idx] = q.wt;
      REQ_SPATIAL: if (q.idx < SPATIAL_DEPTH) shadow_spatial[q.idx] = q.wt;
      default: begin
        pending_pixels.push_back(filter_at(q.r, q.c));
        queries_sent++;
      end
    endcase
  endtask

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one transaction at the falling edge and hold it until accepted.
  task automatic push_request(input request_t q, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    req_type     = q.kind;
    row          = q.r;
    col          = q.c;
    pixel_value  = q.pix;
    table_index  = q.idx;
    weight_value = q.wt;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input request_t q);
    push_request(q, pick_gap());
    absorb(q);
  endtask

  function automatic request_t make_req(input logic [1:0] k, input int r, input int c,
                                        input int pix, input int idx, input int wt);
    request_t q;
    q.kind = k; q.r = r; q.c = c; q.pix = pix; q.idx = idx; q.wt = wt;
    return q;
  endfunction

  // Wait until nothing is owed, then let the block settle after a trailing load.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  sh_width  = val;
      CFG_HEIGHT: sh_height = val;
      CFG_RADIUS: sh_radius = val[2:0];
      CFG_MODE:   sh_mode   = val[1:0];
      default:    sh_fill   = val[7:0];
    endcase
  endtask

  function automatic int rand_weight();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 0;
    if (p == 1) return 16'hFFFF;
    return $urandom_range(0, 65535);
  endfunction

  // Dark or bright pixels only, so every difference lands in 0..15 or 225..255.
  function automatic int rand_pixel();
    int v;
    v = $urandom_range(0, 31);
    return (v < 16) ? v : v + 224;
  endfunction

  // Program a setting and write every pixel of the frame in use.
  task automatic load_setting(input frame_setting_t s);
    int w, h;
    write_reg(CFG_WIDTH, s.w);
    write_reg(CFG_HEIGHT, s.h);
    write_reg(CFG_RADIUS, {6'd0, s.rad});
    write_reg(CFG_MODE, {7'd0, s.mode});
    write_reg(CFG_FILL, {1'b0, s.fill});
    w = clamp_size(s.w, MAX_WIDTH);
    h = clamp_size(s.h, MAX_HEIGHT);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send(make_req(REQ_PIXEL, y, x, rand_pixel(), 0, 0));
  endtask

  // Random traffic: mostly queries, with loads mixed in that reshape the tables.
  function automatic request_t random_req();
    int w, h, p;
    request_t q;
    w = clamp_size(sh_width, MAX_WIDTH);
    h = clamp_size(sh_height, MAX_HEIGHT);
    p = $urandom_range(0, 99);
    q = make_req(REQ_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                 rand_pixel(), $urandom_range(0, 255), rand_weight());
    if (p < 55) begin
      // mostly inside the frame; the rest saturate to the last row and column
      if ($urandom_range(0, 3) != 0) begin
        q.r = $urandom_range(0, h - 1);
        q.c = $urandom_range(0, w - 1);
      end
    end else if (p < 75) begin
      q.kind = REQ_PIXEL;
      if ($urandom_range(0, 3) != 0) begin
        q.r = $urandom_range(0, h - 1);
        q.c = $urandom_range(0, w - 1);
      end
    end else if (p < 87) begin
      q.kind = REQ_RANGE;
    end else begin
      q.kind = REQ_SPATIAL;
      if ($urandom_range(0, 4) != 0) q.idx = $urandom_range(0, SPATIAL_DEPTH - 1);
    end
    return q;
  endfunction

  // Receiver: random stall, long hold-offs on request, calm stretches.
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (left > 0) begin
        left--;
        out_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(20, 60);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare each delivered pixel with the oldest one owed.
  always @(posedge clk) begin
    filtered_t owed;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result: pixel %0d zero_weight %0d",
                 $time, filtered_value, zero_weight);
        errors++;
      end else begin
        owed = pending_pixels.pop_front();
        if (owed.pix !== filtered_value) begin
          $display("%0t: filtered_value expected %0d actual %0d",
                   $time, owed.pix, filtered_value);
          errors++;
        end
        if (owed.zero !== zero_weight) begin
          $display("%0t: zero_weight expected %0d actual %0d",
                   $time, owed.zero, zero_weight);
          errors++;
        end
        if (zero_weight) zero_seen++;
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t  dir_rows[$];
    frame_setting_t settings[$];
    directed_row_t  dr;
    request_t       q;

    // 4x4 replicate frame with radius 1 for the directed part.
    settings.push_back('{w: 9'd4, h: 9'd4,  rad: 3'd1, mode: EDGE_CLAMP, fill: 8'd0});
    settings.push_back('{w: 9'd6, h: 9'd5,  rad: 3'd3, mode: EDGE_FILL,  fill: 8'd255});
    // windows far wider than the frame
    settings.push_back('{w: 9'd9, h: 9'd1,  rad: 3'd7, mode: EDGE_WRAP,  fill: 8'd0});
    // unused mode acts as wrap
    settings.push_back('{w: 9'd1, h: 9'd10, rad: 3'd7, mode: 2'd3,       fill: 8'd250});
    // zero sizes and radius act as one
    settings.push_back('{w: 9'd0, h: 9'd0,  rad: 3'd0, mode: EDGE_FILL,  fill: 8'd255});
    settings.push_back('{w: 9'd5, h: 9'd3,  rad: 3'd7, mode: EDGE_CLAMP, fill: 8'd9});
    settings.push_back('{w: 9'd7, h: 9'd4,  rad: 3'd2, mode: EDGE_WRAP,  fill: 8'd240});

    // Directed rows: extremes, every request kind, ignored spatial index, saturating query,
    // and a window whose spatial weights are all zero so the centre comes back.
    dir_rows.push_back('{make_req(REQ_PIXEL, 0, 0, 0, 0, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_PIXEL, 3, 3, 255, 0, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_PIXEL, 1, 1, 8'hF5, 0, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_PIXEL, 200, 200, 8'hA5, 0, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_RANGE, 0, 0, 0, 0, 16'hFFFF), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_RANGE, 0, 0, 0, 255, 16'hFFFF), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_SPATIAL, 0, 0, 0, 224, 16'hFFFF), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_SPATIAL, 0, 0, 0, 255, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_QUERY, 0, 0, 0, 0, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_QUERY, 255, 255, 0, 0, 0), 0, 0, 0});
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        dir_rows.push_back('{make_req(REQ_SPATIAL, 0, 0, 0,
                             (dy + MAX_RADIUS) * SPAN + dx + MAX_RADIUS, 0), 0, 0, 0});
    dir_rows.push_back('{make_req(REQ_QUERY, 1, 1, 0, 0, 0), 1, 8'hF5, 1'b1});
    dir_rows.push_back('{make_req(REQ_QUERY, 3, 3, 0, 0, 0), 1, 8'd255, 1'b1});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the range entries that pixel differences can reach, then the spatial table.
    for (int i = 0; i < RANGE_DEPTH; i++)
      if (i < 16 || i >= 225) send(make_req(REQ_RANGE, 0, 0, 0, i, rand_weight()));
    for (int i = 0; i < SPATIAL_DEPTH; i++)
      send(make_req(REQ_SPATIAL, 0, 0, 0, i, rand_weight()));

    foreach (settings[s]) begin
      load_setting(settings[s]);
      if (s == 0) begin
        calm = 1'b1;
        foreach (dir_rows[i]) begin
          dr = dir_rows[i];
          push_request(dr.req, 0);
          // typed rows carry their own answer; the rest go through the shadow
          if (dr.typed) begin
            pending_pixels.push_back('{pix: dr.exp_pix, zero: dr.exp_zero});
            queries_sent++;
          end else begin
            absorb(dr.req);
          end
        end
        calm = 1'b0;
      end
      if (s == 1) long_hold_req = 1'b1;  // block fills up behind a stalled receiver
      calm = (s == 5);                   // one setting runs back to back
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        if (s == 3 && n == RANDOM_PER_SET / 2) begin
          // hold off the sender until every owed pixel is in
          @(negedge clk);
          in_valid = 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk);
        end
        q = random_req();
        send(q);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d frame settings, %0d queries, %0d zero-weight results.",
             settings.size(), queries_sent, zero_seen);
    $display("Border modes replicate/constant/wrap/unused, radius 1..7, windows wider than the frame.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bfg_pkg.sv
rtl/core/bfg_ram.sv
rtl/core/bfg_ctrl.sv
rtl/core/bfg_datapath.sv
rtl/core/bilateral_filter_gray.sv
dv/tb_bilateral_filter_gray.sv
